>>> rtl/core/olpd_pkg.sv
// Shared types and constants for the ordered list core.
// No dependencies; olpd_ctrl and the top level in rtl/core use this package.
`timescale 1ns / 1ps

package olpd_pkg;

    // Default list capacity and fixed field widths.
    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int COUNT_OUT_W  = 5;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 40;

    // Request operation codes.
    typedef enum logic [1:0] {
        FN_INS_FRONT = 2'd0,
        FN_INS_BACK  = 2'd1,
        FN_REM_FIRST = 2'd2,
        FN_REM_POS   = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One finished result, handed from the sequencer to the output register.
    typedef struct packed {
        logic                          empty;
        logic [COUNT_OUT_W-1:0]        count;
        logic signed [DATA_W-1:0]      value;
        status_t                       status;
    } result_t;

endpackage

>>> rtl/core/olpd_mem.sv
// Entry storage for the ordered list: one write port, one read port.
// Read data is registered. Depends on nothing else.
`timescale 1ns / 1ps

module olpd_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/olpd_ctrl.sv
// Request sequencer: keeps head and count of the circular entry buffer and
// runs reads, shifts and writes against olpd_mem. Uses olpd_pkg.
`timescale 1ns / 1ps

module olpd_ctrl #(
    parameter int CAPACITY = olpd_pkg::CAPACITY_DEF,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  olpd_pkg::func_t               req_func,
    input  logic [olpd_pkg::DATA_W-1:0]   req_value,
    input  logic [olpd_pkg::POS_W-1:0]    req_pos,
    // Result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output olpd_pkg::result_t             res,
    // Memory port
    output logic                          mem_wr_en,
    output logic [IDX_W-1:0]              mem_wr_addr,
    output logic [olpd_pkg::DATA_W-1:0]   mem_wr_data,
    output logic                          mem_rd_en,
    output logic [IDX_W-1:0]              mem_rd_addr,
    input  logic [olpd_pkg::DATA_W-1:0]   mem_rd_data
);

    localparam int CMP_W = ((CNT_W > olpd_pkg::POS_W) ? CNT_W : olpd_pkg::POS_W) + 1;
    localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W+1)'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    olpd_pkg::status_t             status_reg, status_next;
    logic [olpd_pkg::DATA_W-1:0]   value_reg, value_next;

    logic [CMP_W-1:0]              cnt_ext;
    logic [CMP_W-1:0]              idx_ext;
    logic [CMP_W-1:0]              pos_ext;
    logic                          full;
    logic [CNT_W+olpd_pkg::COUNT_OUT_W-1:0] cnt_wide;

    // Logical list index to physical memory address, wrapping once.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] lidx);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= CAP_SUM)
        begin
            sum = sum - CAP_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign cnt_ext = CMP_W'(cnt_reg);
    assign idx_ext = CMP_W'(idx_reg);
    assign pos_ext = CMP_W'(req_pos);
    assign full    = (cnt_reg == CAP_CNT);
    assign cnt_wide = {{olpd_pkg::COUNT_OUT_W{1'b0}}, cnt_reg};

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    // Result word built from the settled state.
    always_comb
    begin
        res.status = status_reg;
        res.value  = value_reg;
        res.count  = cnt_wide[olpd_pkg::COUNT_OUT_W-1:0];
        res.empty  = (cnt_reg == '0);
    end

    // Sequencer next-state and memory control.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        value_next  = value_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = head_reg;
        mem_wr_data = req_value;
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = olpd_pkg::STATUS_OK;
                    value_next  = '0;
                    unique case (req_func)
                        olpd_pkg::FN_INS_FRONT:
                        begin
                            state_next = ST_DONE;
                            if (full)
                            begin
                                status_next = olpd_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                head_next   = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = head_next;
                                cnt_next    = cnt_reg + 1'b1;
                            end
                        end
                        olpd_pkg::FN_INS_BACK:
                        begin
                            state_next = ST_DONE;
                            if (full)
                            begin
                                status_next = olpd_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = phys(head_reg, IDX_W'(cnt_reg));
                                cnt_next    = cnt_reg + 1'b1;
                            end
                        end
                        olpd_pkg::FN_REM_FIRST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = olpd_pkg::STATUS_EMPTY;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = head_reg;
                                idx_next    = '0;
                                state_next  = ST_FETCH;
                            end
                        end
                        olpd_pkg::FN_REM_POS:
                        begin
                            if ((cnt_reg == '0) || (pos_ext >= cnt_ext))
                            begin
                                status_next = olpd_pkg::STATUS_EMPTY;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = phys(head_reg, IDX_W'(req_pos));
                                idx_next    = IDX_W'(req_pos);
                                state_next  = ST_FETCH;
                            end
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                // Target word is on the read port now.
                value_next = mem_rd_data;
                if (idx_reg == '0)
                begin
                    // Front removal just moves the head.
                    head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_DONE;
                end
                else if ((idx_ext + 1'b1) < cnt_ext)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys(head_reg, idx_reg + 1'b1);
                    state_next  = ST_SHIFT;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                // Move the next entry down one slot, prefetching the one after.
                mem_wr_en   = 1'b1;
                mem_wr_addr = phys(head_reg, idx_reg);
                mem_wr_data = mem_rd_data;
                idx_next    = idx_reg + 1'b1;
                if ((idx_ext + 2'd2) < cnt_ext)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys(head_reg, idx_reg + 2'd2);
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CAP_CNT)
        else $error("olpd_ctrl: count above capacity");

    // The head always points inside the buffer.
    assert property (@(posedge clk) disable iff (!rst_n) head_reg <= LAST_IDX)
        else $error("olpd_ctrl: head outside buffer");

    // A shift never writes the word it is reading in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("olpd_ctrl: read and write hit the same entry");

    // Shifting only happens with at least two entries present.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (cnt_ext >= CMP_W'(2)))
        else $error("olpd_ctrl: shift with fewer than two entries");

    // A handed-off result returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == ST_IDLE))
        else $error("olpd_ctrl: no return to idle after result");

endmodule

>>> rtl/core/ordered_list_with_positional_delete_core.sv
// Top level of the ordered list core: stream ports, sequencer, storage and
// output register. Depends on olpd_pkg, olpd_mem and olpd_ctrl.
//
//  Channel  | Direction | Word contents (lowest bit first)
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | func[1:0], value_in[33:2], position[41:34], 0 pad
//  m_*      | out       | status[1:0], value_out[33:2], count_out[38:34],
//           |           | is_empty[39]
//
// From acceptance until the next word can be accepted, an insert or a
// refused request passes through ST_DONE only, and removing the first
// entry through ST_FETCH and ST_DONE. Removing at position p > 0 adds one
// ST_SHIFT step per entry moved through the single memory read/write port.
// The result enters the output register as the sequencer returns to idle.
// Reset clears head and count; entry storage is not cleared.
// A new word is accepted while the previous result waits in the output
// register; the sequencer stalls only when both are occupied.
`timescale 1ns / 1ps

module ordered_list_with_positional_delete_core #(
    parameter int CAPACITY = olpd_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [olpd_pkg::IN_TDATA_W-1:0]     s_tdata,  // func, value_in, position
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [olpd_pkg::OUT_TDATA_W-1:0]    m_tdata   // status, value_out, count_out, is_empty
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    olpd_pkg::func_t                 req_func;
    logic [olpd_pkg::DATA_W-1:0]     req_value;
    logic [olpd_pkg::POS_W-1:0]      req_pos;
    logic                            res_valid;
    logic                            res_ready;
    olpd_pkg::result_t               res;
    logic                            mem_wr_en;
    logic [IDX_W-1:0]                mem_wr_addr;
    logic [olpd_pkg::DATA_W-1:0]     mem_wr_data;
    logic                            mem_rd_en;
    logic [IDX_W-1:0]                mem_rd_addr;
    logic [olpd_pkg::DATA_W-1:0]     mem_rd_data;

    logic                            out_valid_reg, out_valid_next;
    olpd_pkg::result_t               out_data_reg;

    // Unpack the input word.
    assign req_func  = olpd_pkg::func_t'(s_tdata[1:0]);
    assign req_value = s_tdata[33:2];
    assign req_pos   = s_tdata[41:34];

    olpd_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_func    (req_func),
        .req_value   (req_value),
        .req_pos     (req_pos),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    olpd_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (olpd_pkg::DATA_W),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: loads when empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    // Pack the output word.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.empty, out_data_reg.count,
                       out_data_reg.value, out_data_reg.status};

endmodule
